// ===== src/lzpd_pkg.sv =====
// Shared types and constants for the LZSS palette decompressor.
// Used by lzpd_ctrl, lzpd_datapath and the top level; depends on nothing.
package lzpd_pkg;

  localparam int WIN_DEPTH  = 4096;
  localparam int WIN_AW     = 12;
  localparam int CFG_DATA_W = 24;
  localparam int COPY_BIAS  = 3;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_PALETTE = 2'd2;

  localparam logic CFG_COLOR_COUNT = 1'b0;
  localparam logic CFG_PIXEL_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_REF2
  } phase_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic        stream_end;
    logic [7:0]  palette_index;
    logic [15:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [23:0] pixel_position;
    logic        last_of_run;
    logic        image_done;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic clr_step;
    logic rd;
    logic wr;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_start;
    logic go_lit;
    logic go_copy;
    logic clr_last;
    logic pend_last;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== src/lzpd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lzpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lzpd_ctrl.sv =====
// Controller state machine of the LZSS palette decompressor.
// Depends on lzpd_pkg; drives lzpd_datapath through command and status structs.
module lzpd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lzpd_pkg::ctrl_status_t st_i,
  output lzpd_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_WRITE,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (st_i.go_start) begin
            state_d = S_CLEAR;
          end else if (st_i.go_lit) begin
            state_d = S_WRITE;
          end else if (st_i.go_copy) begin
            state_d = S_READ;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = st_i.pend_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && st_i.go_start) |=> state_q == S_CLEAR)
    else $error("start item did not begin the window clear");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && st_i.clr_last) |=> state_q == S_IDLE)
    else $error("window clear did not end after the last entry");

endmodule

// ===== src/lzpd_datapath.sv =====
// Datapath of the LZSS palette decompressor: parser state, window and palette RAMs,
// pixel counter and output register. Depends on lzpd_pkg and lzpd_ram.
module lzpd_datapath #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lzpd_pkg::in_item_t                  in_item_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [lzpd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  lzpd_pkg::ctrl_cmd_t                 cmd_i,
  output lzpd_pkg::ctrl_status_t              st_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lzpd_pkg::out_item_t                 out_item_o
);

  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] PAL_LIM = 9'(PALETTE_DEPTH);

  logic [lzpd_pkg::WIN_AW-1:0] wpos_q, clr_q, dist_q;
  logic [23:0]                 pix_q, limit_q, pend_pos_q;
  logic [8:0]                  cc_q;
  logic [7:0]                  flag_q, ref1_q, byte_q;
  logic [3:0]                  left_q;
  lzpd_pkg::phase_e            phase_q;
  logic                        active_q, copy_q, out_valid_q;
  logic [4:0]                  remain_q;
  logic                        pend_last_q, pend_done_q;
  lzpd_pkg::out_item_t         out_q;

  logic [7:0]                  win_rdata, sym;
  logic [15:0]                 pal_rdata;
  logic [lzpd_pkg::WIN_AW-1:0] win_waddr;
  logic [7:0]                  win_wdata;
  logic                        win_we, pal_we, pix_lt, byte_live, pend_done_d;
  logic [PAW-1:0]              pal_raddr;
  logic [7:0]                  flag_nt;
  logic [3:0]                  left_nt;
  lzpd_pkg::phase_e            phase_nt;
  logic [23:0]                 pix_inc;

  always_comb begin
    pix_lt    = pix_q < limit_q;
    byte_live = in_item_i.command == lzpd_pkg::CMD_BYTE && active_q && pix_lt;
    flag_nt   = flag_q >> 1;
    left_nt   = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
    phase_nt  = (left_nt == 4'd0) ? lzpd_pkg::PH_FLAG : lzpd_pkg::PH_TOKEN;
    pix_inc   = pix_q + 24'd1;
    pend_done_d = (pix_inc == limit_q);

    st_o.go_start  = in_item_i.command == lzpd_pkg::CMD_START;
    st_o.go_lit    = byte_live && phase_q == lzpd_pkg::PH_TOKEN && flag_q[0];
    st_o.go_copy   = byte_live && phase_q == lzpd_pkg::PH_REF2;
    st_o.clr_last  = clr_q == lzpd_pkg::WIN_AW'(lzpd_pkg::WIN_DEPTH - 1);
    st_o.pend_last = pend_last_q;
    st_o.out_free  = !out_valid_q || out_ready_i;

    sym       = copy_q ? win_rdata : byte_q;
    win_we    = cmd_i.clr_step || cmd_i.wr;
    win_waddr = cmd_i.clr_step ? clr_q : wpos_q;
    win_wdata = cmd_i.clr_step ? 8'd0 : sym;

    pal_we = cmd_i.take && in_item_i.command == lzpd_pkg::CMD_PALETTE &&
             ({1'b0, in_item_i.palette_index} < PAL_LIM);
    if (({1'b0, sym} >= cc_q) || ({1'b0, sym} >= PAL_LIM)) begin
      pal_raddr = '0;
    end else begin
      pal_raddr = sym[PAW-1:0];
    end
  end

  lzpd_ram #(
    .WIDTH(8),
    .DEPTH(lzpd_pkg::WIN_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(win_waddr),
    .wdata_i(win_wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(wpos_q - dist_q),
    .rdata_o(win_rdata)
  );

  lzpd_ram #(
    .WIDTH(16),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(in_item_i.palette_index[PAW-1:0]),
    .wdata_i(in_item_i.palette_color),
    .re_i   (cmd_i.wr),
    .raddr_i(pal_raddr),
    .rdata_o(pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q      <= '0;
      clr_q       <= '0;
      pix_q       <= '0;
      limit_q     <= 24'hFFFFFF;
      cc_q        <= 9'd256;
      flag_q      <= '0;
      ref1_q      <= '0;
      left_q      <= '0;
      phase_q     <= lzpd_pkg::PH_FLAG;
      active_q    <= 1'b0;
      copy_q      <= 1'b0;
      remain_q    <= '0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          lzpd_pkg::CFG_COLOR_COUNT: cc_q    <= cfg_data_i[8:0];
          lzpd_pkg::CFG_PIXEL_LIMIT: limit_q <= cfg_data_i[23:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.take) begin
        case (in_item_i.command)
          lzpd_pkg::CMD_START: begin
            wpos_q   <= '0;
            clr_q    <= '0;
            pix_q    <= '0;
            flag_q   <= '0;
            left_q   <= '0;
            phase_q  <= lzpd_pkg::PH_FLAG;
            ref1_q   <= '0;
            active_q <= 1'b1;
          end
          lzpd_pkg::CMD_BYTE: begin
            if (active_q) begin
              if (pix_lt) begin
                case (phase_q)
                  lzpd_pkg::PH_FLAG: begin
                    flag_q  <= in_item_i.data_byte;
                    left_q  <= 4'd8;
                    phase_q <= lzpd_pkg::PH_TOKEN;
                  end
                  lzpd_pkg::PH_TOKEN: begin
                    if (flag_q[0]) begin
                      flag_q   <= flag_nt;
                      left_q   <= left_nt;
                      phase_q  <= phase_nt;
                      copy_q   <= 1'b0;
                      remain_q <= 5'd1;
                    end else begin
                      ref1_q  <= in_item_i.data_byte;
                      phase_q <= lzpd_pkg::PH_REF2;
                    end
                  end
                  lzpd_pkg::PH_REF2: begin
                    flag_q   <= flag_nt;
                    left_q   <= left_nt;
                    phase_q  <= phase_nt;
                    copy_q   <= 1'b1;
                    remain_q <= 5'(in_item_i.data_byte[3:0]) + 5'(lzpd_pkg::COPY_BIAS);
                  end
                  default: begin
                  end
                endcase
              end
              if (in_item_i.stream_end) begin
                active_q <= 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 12'd1;
      end
      if (cmd_i.wr) begin
        wpos_q      <= wpos_q + 12'd1;
        pix_q       <= pix_inc;
        remain_q    <= remain_q - 5'd1;
        pend_last_q <= (remain_q == 5'd1) || pend_done_d;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_item_i.command == lzpd_pkg::CMD_BYTE) begin
      byte_q <= in_item_i.data_byte;
      dist_q <= {in_item_i.data_byte[7:4], ref1_q};
    end
    if (cmd_i.wr) begin
      pend_pos_q  <= pix_q;
      pend_done_q <= pend_done_d;
    end
    if (cmd_i.emit) begin
      out_q.pixel          <= pal_rdata;
      out_q.pixel_position <= pend_pos_q;
      out_q.last_of_run    <= pend_last_q;
      out_q.image_done     <= pend_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_one_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({st_o.go_start, st_o.go_lit, st_o.go_copy}))
    else $error("more than one decode decision for one item");

  a_pixel_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |=> pix_q == $past(pix_q) + 24'd1)
    else $error("pixel count did not advance by one per decoded byte");

endmodule

// ===== src/lzss_palette_decompressor_unit.sv =====
// LZSS decompressor (4096-byte window) with palette expansion to RGB565 pixels.
// A literal goes through a window write with palette read, then the output register;
// a back-reference gives up to 18 pixels, each through a window read, a window write
// with palette read, then the output register. A new item is taken only once the
// prior item's last pixel is emitted, and none while a start item clears the window.
// Reset is asynchronous, active low; the stream is inactive until a start item.
module lzss_palette_decompressor_unit #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lzpd_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lzpd_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [lzpd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  lzpd_pkg::ctrl_cmd_t    cmd;
  lzpd_pkg::ctrl_status_t st;

  lzpd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  lzpd_datapath #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== tb/lzss_palette_decompressor_unit_tb.sv =====
// Self-checking testbench for lzss_palette_decompressor_unit: directed and random
// compressed streams, palette writes and register settings, checked against a predictor.
// Depends on lzpd_pkg and the lzss_palette_decompressor_unit RTL only.
`timescale 1ns / 1ps

module lzss_palette_decompressor_unit_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CFG_W = lzpd_pkg::CFG_DATA_W;
  localparam int SETTLE_CYCLES = lzpd_pkg::WIN_DEPTH + 64;
  localparam int DRAIN_CYCLES = 64;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  lzpd_pkg::in_item_t in_item_i;
  logic out_valid_o;
  logic out_ready_i;
  lzpd_pkg::out_item_t out_item_o;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  lzss_palette_decompressor_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state.
  logic [7:0] hist [lzpd_pkg::WIN_DEPTH];
  logic [15:0] pal [256];
  logic [11:0] wr_ptr;
  logic [23:0] pix_cnt;
  logic [7:0] flag_reg;
  logic [3:0] tokens_left;
  lzpd_pkg::phase_e parse_st;
  logic [7:0] ref_lo;
  logic live;
  logic [8:0] cc_reg;
  logic [23:0] limit_reg;
  lzpd_pkg::out_item_t expected_pixels [$];

  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold;
  bit hold_req_tgl;
  int errors;
  int items_sent;
  int starts_sent;
  int pixels_checked;
  int settings_used;
  int cycle_count;
  lzpd_pkg::out_item_t want;

  always begin
    #10 clk_i = 1'b0;
    #10 clk_i = 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels outstanding", $time, expected_pixels.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    forever begin
      @(hold_req_tgl);
      rx_hold <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, got %p", $time, out_item_o);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_item_o.pixel !== want.pixel) begin
          $display("%0t: pixel color mismatch: expected %h, got %h", $time,
                   want.pixel, out_item_o.pixel);
          errors++;
        end
        if (out_item_o.pixel_position !== want.pixel_position) begin
          $display("%0t: pixel_position mismatch: expected %0d, got %0d", $time,
                   want.pixel_position, out_item_o.pixel_position);
          errors++;
        end
        if (out_item_o.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run mismatch at pixel %0d: expected %b, got %b", $time,
                   want.pixel_position, want.last_of_run, out_item_o.last_of_run);
          errors++;
        end
        if (out_item_o.image_done !== want.image_done) begin
          $display("%0t: image_done mismatch at pixel %0d: expected %b, got %b", $time,
                   want.pixel_position, want.image_done, out_item_o.image_done);
          errors++;
        end
        pixels_checked++;
      end
    end
  end

  function automatic void emit_pixel(input logic [7:0] sym);
    lzpd_pkg::out_item_t px;
    logic [7:0] idx;
    idx = (sym < cc_reg) ? sym : 8'd0;
    hist[wr_ptr] = sym;
    wr_ptr = wr_ptr + 12'd1;
    px.pixel = pal[idx];
    px.pixel_position = pix_cnt;
    px.last_of_run = 1'b0;
    pix_cnt = pix_cnt + 24'd1;
    px.image_done = (pix_cnt == limit_reg);
    expected_pixels.push_back(px);
  endfunction

  function automatic void advance_token();
    flag_reg = flag_reg >> 1;
    if (tokens_left > 0) tokens_left = tokens_left - 4'd1;
    parse_st = (tokens_left == 0) ? lzpd_pkg::PH_FLAG : lzpd_pkg::PH_TOKEN;
  endfunction

  task automatic decode_item(input lzpd_pkg::in_item_t it);
    int produced;
    int run_len;
    int k;
    logic [11:0] back_dist;
    lzpd_pkg::out_item_t tail;
    produced = 0;
    case (it.command)
      lzpd_pkg::CMD_START: begin
        foreach (hist[i]) hist[i] = 8'h00;
        wr_ptr = '0;
        pix_cnt = '0;
        flag_reg = '0;
        tokens_left = '0;
        parse_st = lzpd_pkg::PH_FLAG;
        ref_lo = '0;
        live = 1'b1;
        starts_sent++;
      end
      lzpd_pkg::CMD_PALETTE: pal[it.palette_index] = it.palette_color;
      lzpd_pkg::CMD_BYTE: begin
        if (live) begin
          if (pix_cnt < limit_reg) begin
            case (parse_st)
              lzpd_pkg::PH_FLAG: begin
                flag_reg = it.data_byte;
                tokens_left = 4'd8;
                parse_st = lzpd_pkg::PH_TOKEN;
              end
              lzpd_pkg::PH_TOKEN: begin
                if (flag_reg[0]) begin
                  emit_pixel(it.data_byte);
                  produced++;
                  advance_token();
                end else begin
                  ref_lo = it.data_byte;
                  parse_st = lzpd_pkg::PH_REF2;
                end
              end
              default: begin
                back_dist = {it.data_byte[7:4], ref_lo};
                run_len = it.data_byte[3:0] + lzpd_pkg::COPY_BIAS;
                for (k = 0; k < run_len && pix_cnt < limit_reg; k++) begin
                  emit_pixel(hist[wr_ptr - back_dist]);
                  produced++;
                end
                advance_token();
              end
            endcase
          end
          if (it.stream_end) live = 1'b0;
        end
      end
      default: ;
    endcase
    if (produced > 0) begin
      tail = expected_pixels.pop_back();
      tail.last_of_run = 1'b1;
      expected_pixels.push_back(tail);
    end
  endtask

  function automatic lzpd_pkg::in_item_t random_item(input logic [1:0] cmd);
    lzpd_pkg::in_item_t it;
    it.command = cmd;
    it.data_byte = 8'($urandom);
    it.stream_end = 1'($urandom);
    it.palette_index = 8'($urandom);
    it.palette_color = 16'($urandom);
    return it;
  endfunction

  function automatic lzpd_pkg::in_item_t stream_byte(input logic [7:0] data,
                                                     input logic last);
    lzpd_pkg::in_item_t it;
    it = random_item(lzpd_pkg::CMD_BYTE);
    it.data_byte = data;
    it.stream_end = last;
    return it;
  endfunction

  function automatic lzpd_pkg::in_item_t palette_write(input logic [7:0] idx,
                                                       input logic [15:0] color,
                                                       input logic last);
    lzpd_pkg::in_item_t it;
    it = random_item(lzpd_pkg::CMD_PALETTE);
    it.palette_index = idx;
    it.palette_color = color;
    it.stream_end = last;
    return it;
  endfunction

  task automatic send_item(input lzpd_pkg::in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    decode_item(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [8:0] colors, input logic [23:0] limit);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= lzpd_pkg::CFG_COLOR_COUNT;
    cfg_data_i <= CFG_W'(colors);
    @(posedge clk_i);
    cfg_index_i <= lzpd_pkg::CFG_PIXEL_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cc_reg = colors;
    limit_reg = limit;
    settings_used++;
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0: send_item(random_item(CMD_UNUSED));
      default: send_item(random_item(lzpd_pkg::CMD_PALETTE));
    endcase
  endtask

  task automatic send_random_stream();
    logic [7:0] stream_bytes [$];
    logic [7:0] flags;
    logic [11:0] back_dist;
    logic mark_end;
    int tokens;
    int slot;
    int cut;
    int i;
    tokens = $urandom_range(4, 24);
    slot = 0;
    flags = '0;
    repeat (tokens) begin
      if (slot == 0) begin
        flags = 8'($urandom);
        stream_bytes.push_back(flags);
      end
      if (flags[slot]) begin
        stream_bytes.push_back(8'($urandom));
      end else begin
        case ($urandom_range(19))
          0: back_dist = '0;
          1, 2, 3: back_dist = 12'($urandom);
          default: back_dist = 12'($urandom_range(1, 40));
        endcase
        stream_bytes.push_back(back_dist[7:0]);
        stream_bytes.push_back({back_dist[11:8], 4'($urandom)});
      end
      slot = (slot + 1) % 8;
    end
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(1, stream_bytes.size());
      while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
    end
    mark_end = ($urandom_range(99) < 85);
    send_item(random_item(lzpd_pkg::CMD_START));
    for (i = 0; i < stream_bytes.size(); i++) begin
      if ($urandom_range(99) < 5) send_noise();
      send_item(stream_byte(stream_bytes[i], mark_end && (i == stream_bytes.size() - 1)));
    end
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 2)) send_item(stream_byte(8'($urandom), 1'($urandom)));
    end
  endtask

  task automatic load_palette();
    int i;
    for (i = 0; i < 256; i++) begin
      send_item(palette_write(8'(i), 16'($urandom), 1'b0));
    end
  endtask

  task automatic test_token_corners();
    send_item(stream_byte(8'hFF, 1'b1));
    send_item(random_item(CMD_UNUSED));
    send_item(palette_write(8'd255, 16'hFFFF, 1'b0));
    send_item(palette_write(8'd0, 16'h0000, 1'b1));
    send_item(random_item(lzpd_pkg::CMD_START));
    // Flags give a reference, two literals, then references.
    send_item(stream_byte(8'h06, 1'b0));
    send_item(stream_byte(8'h00, 1'b0));
    send_item(stream_byte(8'h00, 1'b0));
    send_item(stream_byte(8'hFF, 1'b0));
    send_item(stream_byte(8'h00, 1'b0));
    send_item(stream_byte(8'h01, 1'b0));
    send_item(stream_byte(8'h0F, 1'b0));
    send_item(stream_byte(8'hFF, 1'b0));
    send_item(stream_byte(8'hF5, 1'b0));
    // The stream ends on the first byte of a reference, which is dropped.
    send_item(stream_byte(8'h12, 1'b1));
    send_item(stream_byte(8'h34, 1'b0));
    send_item(random_item(lzpd_pkg::CMD_START));
    send_item(stream_byte(8'hFF, 1'b1));
    send_item(random_item(lzpd_pkg::CMD_START));
    send_item(stream_byte(8'hFF, 1'b0));
    send_item(stream_byte(8'h80, 1'b0));
    send_item(stream_byte(8'h7F, 1'b1));
  endtask

  task automatic test_random_streams(input logic [8:0] colors, input logic [23:0] limit,
                                     input int budget);
    int stop_at;
    set_config(colors, limit);
    stop_at = items_sent + budget;
    while (items_sent < stop_at) send_random_stream();
  endtask

  task automatic test_backpressure();
    int k;
    set_config(9'd256, 24'hFFFFFF);
    send_item(random_item(lzpd_pkg::CMD_START));
    send_item(stream_byte(8'hFF, 1'b0));
    // The receiver goes quiet while eight literals and eight long copies are offered.
    hold_req_tgl = !hold_req_tgl;
    for (k = 0; k < 8; k++) send_item(stream_byte(8'($urandom), 1'b0));
    send_item(stream_byte(8'h00, 1'b0));
    for (k = 0; k < 8; k++) begin
      send_item(stream_byte(8'($urandom_range(1, 16)), 1'b0));
      send_item(stream_byte(8'h0F, 1'b0));
    end
    wait_drained();
    send_item(stream_byte(8'hFF, 1'b0));
    for (k = 0; k < 8; k++) send_item(stream_byte(8'($urandom), k == 7));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = lzpd_pkg::CFG_COLOR_COUNT;
    cfg_data_i = '0;
    foreach (hist[i]) hist[i] = 8'h00;
    foreach (pal[i]) pal[i] = 16'h0000;
    wr_ptr = '0;
    pix_cnt = '0;
    flag_reg = '0;
    tokens_left = '0;
    parse_st = lzpd_pkg::PH_FLAG;
    ref_lo = '0;
    live = 1'b0;
    cc_reg = 9'd256;
    limit_reg = 24'hFFFFFF;
    tx_idle_pct = 14;
    rx_idle_pct = 86;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_palette();
    test_token_corners();
    test_random_streams(9'd0, 24'hFFFFFF, 12);
    test_random_streams(9'd37, 24'd40, 12);
    tx_idle_pct = 86;
    rx_idle_pct = 14;
    test_random_streams(9'd256, 24'd0, 12);
    test_random_streams(9'd1, 24'd100, 12);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_streams(9'd200, 24'd1, 12);
    test_random_streams(9'd256, 24'hFFFFFF, 12);
    test_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived", $time, expected_pixels.size());
      errors++;
    end
    $display("Sent %0d items over %0d streams and %0d register settings; checked %0d pixels.",
             items_sent, starts_sent, settings_used, pixels_checked);
    $display("Idling covered sender-light, receiver-light and none, plus a long output stall.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lzpd_pkg.sv
src/lzpd_ram.sv
src/lzpd_ctrl.sv
src/lzpd_datapath.sv
src/lzss_palette_decompressor_unit.sv
tb/lzss_palette_decompressor_unit_tb.sv
